[rtl/core/spc_pkg.sv]
// Shared types, constants and arithmetic helpers of the pixel compositor.
package spc_pkg;

    // Default frame store geometry
    localparam int FB_WIDTH_DEF  = 256;
    localparam int FB_HEIGHT_DEF = 256;

    // Configuration port
    localparam int CFG_W     = 9;
    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] REG_CANVAS_WIDTH  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CANVAS_HEIGHT = 1'd1;
    localparam logic [CFG_W-1:0]     CANVAS_RESET      = 9'd256;

    // Item fields
    localparam int POS_W = 13;
    localparam int OP_W  = 2;
    localparam int PIX_W = 32;
    localparam logic [OP_W-1:0] OP_BLEND = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    // Queue between front and back
    localparam int Q_DEPTH = 2;
    localparam int Q_PTR_W = 1;
    localparam int Q_CNT_W = 2;

    // Classified command handed from front to back
    typedef struct packed {
        logic [OP_W-1:0]  op;
        logic             in_bounds;
        logic [PIX_W-1:0] src;       // A R G B, alpha in the top byte
    } cmd_t;

    // Queue status seen by both sides
    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    // s*sa + d*(255-sa) + 127, at most 65152
    function automatic logic [15:0] mix_acc(input logic [7:0] s, input logic [7:0] d,
                                            input logic [7:0] sa);
        logic [7:0] inv;
        inv = 8'd255 - sa;
        return 16'(s) * 16'(sa) + 16'(d) * 16'(inv) + 16'd127;
    endfunction

    // Floor of v / 255 for v below 65280 through add-and-shift
    function automatic logic [7:0] div255(input logic [15:0] v);
        logic [16:0] t;
        t = 17'(v) + 17'(v[15:8]) + 17'd1;
        return t[15:8];
    endfunction

endpackage

[rtl/core/spc_front.sv]
// Front end: canvas registers, bounds check and address formation.
module spc_front #(
    parameter int FB_WIDTH  = spc_pkg::FB_WIDTH_DEF,
    parameter int FB_HEIGHT = spc_pkg::FB_HEIGHT_DEF,
    parameter int AW        = $clog2(FB_WIDTH * FB_HEIGHT)
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [spc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [spc_pkg::CFG_W-1:0]     cfg_data,
    input  logic [spc_pkg::OP_W-1:0]      in_op,
    input  logic [spc_pkg::POS_W-1:0]     in_x,
    input  logic [spc_pkg::POS_W-1:0]     in_y,
    input  logic [spc_pkg::PIX_W-1:0]     in_src,
    output spc_pkg::cmd_t                 cmd,
    output logic [AW-1:0]                 addr
);

    localparam int XW = $clog2(FB_WIDTH);
    localparam int YW = $clog2(FB_HEIGHT);
    localparam logic [spc_pkg::POS_W-1:0] LimW = spc_pkg::POS_W'(FB_WIDTH);
    localparam logic [spc_pkg::POS_W-1:0] LimH = spc_pkg::POS_W'(FB_HEIGHT);

    logic [spc_pkg::CFG_W-1:0] cw_reg;
    logic [spc_pkg::CFG_W-1:0] ch_reg;
    logic [spc_pkg::POS_W-1:0] cw_ext;
    logic [spc_pkg::POS_W-1:0] ch_ext;
    logic [spc_pkg::POS_W-1:0] lim_w;
    logic [spc_pkg::POS_W-1:0] lim_h;
    logic                      x_ok;
    logic                      y_ok;

    // Write canvas registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cw_reg <= spc_pkg::CANVAS_RESET;
            ch_reg <= spc_pkg::CANVAS_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                spc_pkg::REG_CANVAS_WIDTH:  cw_reg <= cfg_data;
                spc_pkg::REG_CANVAS_HEIGHT: ch_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Clamp the canvas to the store
    always_comb
    begin
        cw_ext = spc_pkg::POS_W'(cw_reg);
        ch_ext = spc_pkg::POS_W'(ch_reg);
        lim_w  = (cw_ext < LimW) ? cw_ext : LimW;
        lim_h  = (ch_ext < LimH) ? ch_ext : LimH;
    end

    // Classify the coordinate
    assign x_ok = !in_x[spc_pkg::POS_W-1] &&
                  ({1'b0, in_x[spc_pkg::POS_W-2:0]} < lim_w);
    assign y_ok = !in_y[spc_pkg::POS_W-1] &&
                  ({1'b0, in_y[spc_pkg::POS_W-2:0]} < lim_h);

    // Row-major address, stride of one store row
    assign addr = AW'(in_y[YW-1:0]) * AW'(FB_WIDTH) + AW'(in_x[XW-1:0]);

    assign cmd.op        = in_op;
    assign cmd.in_bounds = x_ok && y_ok;
    assign cmd.src       = in_src;

endmodule

[rtl/core/spc_queue.sv]
// Two-entry queue that decouples the front end from the back end.
module spc_queue #(
    parameter int W = 8
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [W-1:0]     din,
    input  logic             pop,
    output logic [W-1:0]     dout,
    output spc_pkg::q_stat_t stat
);

    logic [W-1:0]                 mem_reg [spc_pkg::Q_DEPTH];
    logic [spc_pkg::Q_PTR_W-1:0]  wr_ptr_reg;
    logic [spc_pkg::Q_PTR_W-1:0]  rd_ptr_reg;
    logic [spc_pkg::Q_CNT_W-1:0]  cnt_reg;
    logic [spc_pkg::Q_CNT_W-1:0]  cnt_next;
    logic                         do_push;
    logic                         do_pop;

    assign stat.full  = (cnt_reg == spc_pkg::Q_CNT_W'(spc_pkg::Q_DEPTH));
    assign stat.empty = (cnt_reg == '0);
    assign do_push    = push && !stat.full;
    assign do_pop     = pop && !stat.empty;
    assign dout       = mem_reg[rd_ptr_reg];

    // Track the fill level
    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    // Advance pointers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    // Store entries
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= din;
        end
    end

endmodule

[rtl/core/spc_back.sv]
// Back end: frame store, read-modify-write sequencer, blend datapath, output register.
module spc_back #(
    parameter int DEPTH = spc_pkg::FB_WIDTH_DEF * spc_pkg::FB_HEIGHT_DEF,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  spc_pkg::q_stat_t          q_stat,
    input  spc_pkg::cmd_t             q_cmd,
    input  logic [AW-1:0]             q_addr,
    output logic                      pop,
    output logic                      out_valid,
    input  logic                      out_ready,
    output logic [spc_pkg::PIX_W-1:0] out_pix,
    output logic                      out_inb
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MIX  = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;

    logic [spc_pkg::PIX_W-1:0] store [DEPTH];

    logic [1:0]                state_reg;
    logic [1:0]                state_next;
    spc_pkg::cmd_t             cmd_reg;
    logic [AW-1:0]             addr_reg;
    logic [spc_pkg::PIX_W-1:0] rd_data_reg;
    logic [spc_pkg::PIX_W-1:0] dst_reg;
    logic [15:0]               acc_a_reg;
    logic [15:0]               acc_r_reg;
    logic [15:0]               acc_g_reg;
    logic [15:0]               acc_b_reg;
    logic                      out_valid_reg;
    logic [spc_pkg::PIX_W-1:0] out_pix_reg;
    logic                      out_inb_reg;

    logic                      slot_free;
    logic                      finish;
    logic                      mem_we;
    logic [spc_pkg::PIX_W-1:0] blended;
    logic [spc_pkg::PIX_W-1:0] pix_new;
    logic [7:0]                src_a;

    assign src_a     = cmd_reg.src[31:24];
    assign slot_free = !out_valid_reg || out_ready;
    assign pop       = (state_reg == ST_IDLE) && !q_stat.empty;
    assign finish    = (state_reg == ST_DIV) && slot_free;

    // Sequence one item at a time
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (!q_stat.empty)
                begin
                    state_next = q_cmd.in_bounds ? ST_MIX : ST_DIV;
                end
            end
            ST_MIX:  state_next = ST_DIV;
            ST_DIV:
            begin
                if (slot_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Finish the blend: divide by 255 and add source alpha
    assign blended = {src_a + spc_pkg::div255(acc_a_reg),
                      spc_pkg::div255(acc_r_reg),
                      spc_pkg::div255(acc_g_reg),
                      spc_pkg::div255(acc_b_reg)};

    // Pick the new stored pixel
    always_comb
    begin
        pix_new = dst_reg;
        mem_we  = 1'b0;
        case (cmd_reg.op)
            spc_pkg::OP_BLEND:
            begin
                mem_we = 1'b1;
                if (cmd_reg.src != '0)
                begin
                    pix_new = blended;
                end
            end
            spc_pkg::OP_WRITE:
            begin
                mem_we  = 1'b1;
                pix_new = cmd_reg.src;
            end
            spc_pkg::OP_READ: pix_new = dst_reg;
            default:          pix_new = dst_reg;
        endcase
        mem_we = mem_we && cmd_reg.in_bounds && finish;
    end

    // Control and output handshake
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (finish)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cmd_reg  <= q_cmd;
            addr_reg <= q_addr;
        end
        if (state_reg == ST_MIX)
        begin
            dst_reg   <= rd_data_reg;
            acc_a_reg <= 16'(rd_data_reg[31:24]) * 16'(8'd255 - src_a) + 16'd127;
            acc_r_reg <= spc_pkg::mix_acc(cmd_reg.src[23:16], rd_data_reg[23:16], src_a);
            acc_g_reg <= spc_pkg::mix_acc(cmd_reg.src[15:8], rd_data_reg[15:8], src_a);
            acc_b_reg <= spc_pkg::mix_acc(cmd_reg.src[7:0], rd_data_reg[7:0], src_a);
        end
        if (finish)
        begin
            out_inb_reg <= cmd_reg.in_bounds;
            out_pix_reg <= cmd_reg.in_bounds ? pix_new : '0;
        end
    end

    // Frame store: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            store[addr_reg] <= pix_new;
        end
        rd_data_reg <= store[q_addr];
    end

    assign out_valid = out_valid_reg;
    assign out_pix   = out_pix_reg;
    assign out_inb   = out_inb_reg;

endmodule

[rtl/core/src_over_pixel_compositor.sv]
// Top level of the src-over pixel compositor with its ARGB8888 frame store.
//
//  channel | direction | handshake          | payload
//  --------+-----------+--------------------+--------------------------------------------
//  cfg     | in        | cfg_we             | cfg_index (0 width, 1 height), cfg_data[8:0]
//  s       | in        | s_tvalid/s_tready  | s_tdata x,y,A,R,G,B; s_tuser op
//  m       | out       | m_tvalid/m_tready  | m_tdata A,R,G,B; m_tuser in_bounds
//
// An in-bounds item passes through the back end as store read, multiply-add, then divide and
// write back; an out-of-bounds item skips the multiply-add. The store read is registered, and
// one item is written back before the next is read, so items are taken one at a time. A
// two-entry queue keeps taking items while the back end works or the output register waits.
// Reset clears control state only; the frame store holds garbage until written.
module src_over_pixel_compositor #(
    parameter int FB_WIDTH  = spc_pkg::FB_WIDTH_DEF,
    parameter int FB_HEIGHT = spc_pkg::FB_HEIGHT_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [spc_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [spc_pkg::CFG_W-1:0]     cfg_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // pos_x[12:0], pos_y[25:13], src_alpha[33:26], src_red[41:34],
    // src_green[49:42], src_blue[57:50], zero[63:58]
    input  logic [63:0]                   s_tdata,
    // op[1:0]
    input  logic [spc_pkg::OP_W-1:0]      s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // out_alpha[7:0], out_red[15:8], out_green[23:16], out_blue[31:24]
    output logic [31:0]                   m_tdata,
    // in_bounds[0]
    output logic                          m_tuser
);

    localparam int DEPTH = FB_WIDTH * FB_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int QW    = $bits(spc_pkg::cmd_t) + AW;

    spc_pkg::cmd_t             f_cmd;
    logic [AW-1:0]             f_addr;
    logic [spc_pkg::PIX_W-1:0] in_src;
    logic [QW-1:0]             q_dout;
    spc_pkg::q_stat_t          q_stat;
    spc_pkg::cmd_t             q_cmd;
    logic [AW-1:0]             q_addr;
    logic                      q_pop;
    logic [spc_pkg::PIX_W-1:0] out_pix;

    // Gather the source pixel with alpha on top
    assign in_src = {s_tdata[33:26], s_tdata[41:34], s_tdata[49:42], s_tdata[57:50]};

    spc_front #(
        .FB_WIDTH  (FB_WIDTH),
        .FB_HEIGHT (FB_HEIGHT),
        .AW        (AW)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_op     (s_tuser),
        .in_x      (s_tdata[12:0]),
        .in_y      (s_tdata[25:13]),
        .in_src    (in_src),
        .cmd       (f_cmd),
        .addr      (f_addr)
    );

    assign s_tready = !q_stat.full;

    spc_queue #(
        .W (QW)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (s_tvalid && s_tready),
        .din   ({f_addr, f_cmd}),
        .pop   (q_pop),
        .dout  (q_dout),
        .stat  (q_stat)
    );

    // Split the queue head
    assign q_cmd  = q_dout[$bits(spc_pkg::cmd_t)-1:0];
    assign q_addr = q_dout[QW-1:$bits(spc_pkg::cmd_t)];

    spc_back #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_stat    (q_stat),
        .q_cmd     (q_cmd),
        .q_addr    (q_addr),
        .pop       (q_pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_pix   (out_pix),
        .out_inb   (m_tuser)
    );

    // Alpha goes to the lowest byte on the stream
    assign m_tdata = {out_pix[7:0], out_pix[15:8], out_pix[23:16], out_pix[31:24]};

    // An ignored coordinate reports a zero pixel
    a_oob_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tuser) |-> (m_tdata == '0))
        else $error("out-of-bounds result carries nonzero pixel");

    // Queue cannot be full and empty at once
    a_q_stat: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_stat.full && q_stat.empty))
        else $error("queue status inconsistent");

    // Back end pops only a nonempty queue
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_stat.empty)
        else $error("pop from empty queue");

endmodule
